// ===== sv/mvfi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh index decoder package
// Shared widths, strip codes, command format and delta decoding.
// ----------------------------------------------------------------------------
package mvfi_pkg;

  localparam int CoordW    = 32;
  localparam int DeltaW    = 18;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  localparam int SmallBias = 64;
  localparam int SmartBias = 'hC000;

  localparam logic [7:0] CODE_FULL    = 8'd1;
  localparam logic [7:0] CODE_SHARE_B = 8'd2;
  localparam logic [7:0] CODE_SHARE_A = 8'd3;
  localparam logic [7:0] CODE_SWAP    = 8'd4;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_CODE = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DeltaW-1:0] delta_t;

  typedef enum logic [2:0] {
    OP_VERTEX,
    OP_FULL,
    OP_SHARE_B,
    OP_SHARE_A,
    OP_SWAP,
    OP_BAD
  } op_t;

  // vertex: p0..p2 are the three deltas; face: p0..p2 are running delta sums
  typedef struct packed {
    logic       first;
    op_t        op;
    logic [2:0] axis;
    delta_t     p0;
    delta_t     p1;
    delta_t     p2;
  } cmd_t;

  function automatic delta_t smart_delta(logic [7:0] lead, logic [7:0] tail);
    delta_t r;
    if (!lead[7]) begin
      r = delta_t'(lead) - delta_t'(SmallBias);
    end else begin
      r = delta_t'({lead, tail}) - delta_t'(SmartBias);
    end
    return r;
  endfunction

  function automatic coord_t widen(delta_t d);
    return {{(CoordW-DeltaW){d[DeltaW-1]}}, d};
  endfunction

endpackage

// ===== sv/mvfi_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh index decoder input channel
// Valid/ready channel carrying one encoded vertex or face item.
// ----------------------------------------------------------------------------
interface mvfi_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       first_of_model;
  logic [7:0] code;
  logic [7:0] d0_first;
  logic [7:0] d0_second;
  logic [7:0] d1_first;
  logic [7:0] d1_second;
  logic [7:0] d2_first;
  logic [7:0] d2_second;

  modport source (
    output valid, req_type, first_of_model, code,
    output d0_first, d0_second, d1_first, d1_second, d2_first, d2_second,
    input  ready
  );

  modport sink (
    input  valid, req_type, first_of_model, code,
    input  d0_first, d0_second, d1_first, d1_second, d2_first, d2_second,
    output ready
  );
endinterface

// ===== sv/mvfi_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh index decoder output channel
// Valid/ready channel carrying decoded coordinates or face indices.
// ----------------------------------------------------------------------------
interface mvfi_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               status;
  logic signed [31:0] out_first;
  logic signed [31:0] out_second;
  logic signed [31:0] out_third;

  modport source (
    output valid, kind, status, out_first, out_second, out_third,
    input  ready
  );

  modport sink (
    input  valid, kind, status, out_first, out_second, out_third,
    output ready
  );
endinterface

// ===== sv/mvfi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh index decoder front end
// Accepts items, decodes smart deltas and classifies the operation.
// ----------------------------------------------------------------------------
module mvfi_front
  import mvfi_pkg::*;
(
  mvfi_in_if.sink item,
  input  logic    full,
  output logic    push,
  output cmd_t    push_data
);

  delta_t d0;
  delta_t d1;
  delta_t d2;

  assign item.ready = !full;
  assign push       = item.valid && !full;

  assign d0 = smart_delta(item.d0_first, item.d0_second);
  assign d1 = smart_delta(item.d1_first, item.d1_second);
  assign d2 = smart_delta(item.d2_first, item.d2_second);

  always_comb begin
    push_data.first = item.first_of_model;
    push_data.axis  = item.code[2:0];
    push_data.op    = OP_BAD;
    push_data.p0    = d0;
    push_data.p1    = d1;
    push_data.p2    = d2;
    if (item.req_type == KIND_VERTEX) begin
      push_data.op = OP_VERTEX;
    end else begin
      // prefix sums keep the face adds parallel in the back end
      push_data.p1 = d0 + d1;
      push_data.p2 = d0 + d1 + d2;
      unique case (item.code)
        CODE_FULL:    push_data.op = OP_FULL;
        CODE_SHARE_B: push_data.op = OP_SHARE_B;
        CODE_SHARE_A: push_data.op = OP_SHARE_A;
        CODE_SWAP:    push_data.op = OP_SWAP;
        default:      push_data.op = OP_BAD;
      endcase
    end
  end

endmodule

// ===== sv/mvfi_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh index decoder command queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module mvfi_queue
  import mvfi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  cmd_t                entries [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoPtrW:0]   count;

  assign full      = (count == (FifoPtrW+1)'(FifoDepth));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FifoPtrW+1)'(push) - (FifoPtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !pop_valid))
    else $error("pop from empty queue");

endmodule

// ===== sv/mvfi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh index decoder back end
// Holds running coordinates and indices, executes commands, registers results.
// ----------------------------------------------------------------------------
module mvfi_back
  import mvfi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  input  cmd_t        pop_data,
  output logic        pop,
  mvfi_out_if.source  result
);

  coord_t prev_x, prev_y, prev_z;
  coord_t index_a, index_b, index_c, last_index;

  coord_t base_x, base_y, base_z, base_a, base_b, base_c, base_last;
  coord_t prev_x_next, prev_y_next, prev_z_next;
  coord_t index_a_next, index_b_next, index_c_next, last_index_next;

  logic   res_valid;
  logic   res_kind;
  logic   res_status;
  coord_t res_first, res_second, res_third;

  logic   kind_next;
  logic   status_next;
  coord_t first_next, second_next, third_next;

  assign pop = pop_valid && (!res_valid || result.ready);

  always_comb begin
    base_x    = pop_data.first ? '0 : prev_x;
    base_y    = pop_data.first ? '0 : prev_y;
    base_z    = pop_data.first ? '0 : prev_z;
    base_a    = pop_data.first ? '0 : index_a;
    base_b    = pop_data.first ? '0 : index_b;
    base_c    = pop_data.first ? '0 : index_c;
    base_last = pop_data.first ? '0 : last_index;

    prev_x_next  = base_x;
    prev_y_next  = base_y;
    prev_z_next  = base_z;
    index_a_next = base_a;
    index_b_next = base_b;
    index_c_next = base_c;
    kind_next    = KIND_FACE;
    status_next  = STATUS_OK;

    unique case (pop_data.op)
      OP_VERTEX: begin
        kind_next   = KIND_VERTEX;
        prev_x_next = base_x + (pop_data.axis[0] ? widen(pop_data.p0) : '0);
        prev_y_next = base_y + (pop_data.axis[1] ? widen(pop_data.p1) : '0);
        prev_z_next = base_z + (pop_data.axis[2] ? widen(pop_data.p2) : '0);
      end
      OP_FULL: begin
        index_a_next = base_last + widen(pop_data.p0);
        index_b_next = base_last + widen(pop_data.p1);
        index_c_next = base_last + widen(pop_data.p2);
      end
      OP_SHARE_B: begin
        index_b_next = base_c;
        index_c_next = base_last + widen(pop_data.p0);
      end
      OP_SHARE_A: begin
        index_a_next = base_c;
        index_c_next = base_last + widen(pop_data.p0);
      end
      OP_SWAP: begin
        index_a_next = base_b;
        index_b_next = base_a;
        index_c_next = base_last + widen(pop_data.p0);
      end
      default: begin
        status_next = STATUS_BAD_CODE;
      end
    endcase

    last_index_next = (status_next == STATUS_BAD_CODE) ? base_last : index_c_next;

    if (kind_next == KIND_VERTEX) begin
      first_next  = prev_x_next;
      second_next = prev_y_next;
      third_next  = prev_z_next;
    end else if (status_next == STATUS_BAD_CODE) begin
      first_next  = '0;
      second_next = '0;
      third_next  = '0;
    end else begin
      first_next  = index_a_next;
      second_next = index_b_next;
      third_next  = index_c_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x     <= '0;
      prev_y     <= '0;
      prev_z     <= '0;
      index_a    <= '0;
      index_b    <= '0;
      index_c    <= '0;
      last_index <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (pop) begin
        prev_x     <= prev_x_next;
        prev_y     <= prev_y_next;
        prev_z     <= prev_z_next;
        index_a    <= index_a_next;
        index_b    <= index_b_next;
        index_c    <= index_c_next;
        last_index <= last_index_next;
        res_valid  <= 1'b1;
      end else if (result.ready) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_kind   <= kind_next;
      res_status <= status_next;
      res_first  <= first_next;
      res_second <= second_next;
      res_third  <= third_next;
    end
  end

  assign result.valid      = res_valid;
  assign result.kind       = res_kind;
  assign result.status     = res_status;
  assign result.out_first  = res_first;
  assign result.out_second = res_second;
  assign result.out_third  = res_third;

  a_last_tracks_c: assert property (@(posedge clk) disable iff (rst)
    last_index == index_c)
    else $error("last index diverged from index c");
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> res_valid)
    else $error("popped item produced no result");
  a_bad_is_face: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == STATUS_BAD_CODE) |->
      (res_kind == KIND_FACE) && (res_first == '0) && (res_second == '0)
      && (res_third == '0))
    else $error("bad code result malformed");
  a_bad_keeps_state: assert property (@(posedge clk) disable iff (rst)
    pop && (pop_data.op == OP_BAD) && !pop_data.first |=>
      $stable(index_a) && $stable(index_b) && $stable(index_c)
      && $stable(prev_x))
    else $error("bad code changed state");

endmodule

// ===== sv/mesh_vertex_and_face_index_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex and face index decoder
// Decodes delta-coded vertex coordinates and triangle strip indices.
// ----------------------------------------------------------------------------
// Usage:
//   item   - valid/ready input; one encoded vertex or face item per transfer.
//   result - valid/ready output; exactly one result per item, in order.
//   An item is accepted whenever the two-entry command queue has room, so
//   ready stays high while results are being taken.
//   Path: an accepted item is written into the command queue, and the back
//   end then executes it into the output register once that register is
//   empty or being read (result.ready high).
//   Throughput: one item per cycle while result.ready is high, set by the
//   single back-end execute stage owning running coordinates and indices.
//   Reset (rst, synchronous): clears all running state, empties the queue
//   and drops any pending result.
//   Stall: while result.ready is low the output register holds; the queue
//   absorbs up to two more items, then item.ready falls.
// ----------------------------------------------------------------------------
module mesh_vertex_and_face_index_decoder
  import mvfi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mvfi_in_if.sink    item,
  mvfi_out_if.source result
);

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  logic pop_valid;
  cmd_t pop_data;

  mvfi_front u_front (
    .item      (item),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  mvfi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  mvfi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== test/tb_mesh_vertex_and_face_index_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex and face index decoder testbench
// Sends directed and random vertex and face items through the valid/ready
// input, with random gaps and one long output stall. It tracks the running
// coordinates and strip indices on its own and checks every result in order.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_and_face_index_decoder;
  import mvfi_pkg::*;

  localparam int RandomItems = 1600;
  localparam int CycleLimit  = 400000;
  localparam int HoldAfter   = 200;
  localparam int HoldCycles  = 150;

  typedef struct {
    logic       req_type;
    logic       first_of_model;
    logic [7:0] code;
    logic [7:0] d0_first;
    logic [7:0] d0_second;
    logic [7:0] d1_first;
    logic [7:0] d1_second;
    logic [7:0] d2_first;
    logic [7:0] d2_second;
  } mesh_item_t;

  typedef struct {
    logic        kind;
    logic        status;
    logic [31:0] first;
    logic [31:0] second;
    logic [31:0] third;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mvfi_in_if  item_if ();
  mvfi_out_if result_if ();

  mesh_vertex_and_face_index_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  mesh_item_t stim_q[$];
  decoded_t   decoded_q[$];
  mesh_item_t cur_item;
  decoded_t   got;
  decoded_t   want;

  logic [31:0] pos_x, pos_y, pos_z;
  logic [31:0] idx_a, idx_b, idx_c, last_idx;

  int errors        = 0;
  int items_sent    = 0;
  int results_taken = 0;
  int total_items   = 0;
  int send_gap      = 0;
  int send_calm     = 0;
  int sink_wait     = 0;
  int sink_calm     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int cycles        = 0;

  logic [7:0] strip_codes[4] = '{CODE_FULL, CODE_SHARE_B, CODE_SHARE_A, CODE_SWAP};

  function automatic logic [31:0] smart_value(logic [7:0] lead, logic [7:0] tail);
    if (!lead[7]) return {24'd0, lead} - 32'(SmallBias);
    return {16'd0, lead, tail} - 32'(SmartBias);
  endfunction

  function automatic decoded_t decode_item(mesh_item_t it);
    decoded_t    r;
    logic [31:0] d0, d1, d2, swap;
    d0 = smart_value(it.d0_first, it.d0_second);
    d1 = smart_value(it.d1_first, it.d1_second);
    d2 = smart_value(it.d2_first, it.d2_second);
    if (it.first_of_model) begin
      pos_x = '0; pos_y = '0; pos_z = '0;
      idx_a = '0; idx_b = '0; idx_c = '0; last_idx = '0;
    end
    r.kind   = it.req_type;
    r.status = STATUS_OK;
    if (it.req_type == KIND_VERTEX) begin
      if (it.code[0]) pos_x = pos_x + d0;
      if (it.code[1]) pos_y = pos_y + d1;
      if (it.code[2]) pos_z = pos_z + d2;
      r.first  = pos_x;
      r.second = pos_y;
      r.third  = pos_z;
      return r;
    end
    case (it.code)
      CODE_FULL: begin
        idx_a = d0 + last_idx;
        idx_b = d1 + idx_a;
        idx_c = d2 + idx_b;
      end
      CODE_SHARE_B: begin
        idx_b = idx_c;
        idx_c = d0 + last_idx;
      end
      CODE_SHARE_A: begin
        idx_a = idx_c;
        idx_c = d0 + last_idx;
      end
      CODE_SWAP: begin
        swap  = idx_a;
        idx_a = idx_b;
        idx_b = swap;
        idx_c = d0 + last_idx;
      end
      default: begin
        r.status = STATUS_BAD_CODE;
        r.first  = '0;
        r.second = '0;
        r.third  = '0;
        return r;
      end
    endcase
    last_idx = idx_c;
    r.first  = idx_a;
    r.second = idx_b;
    r.third  = idx_c;
    return r;
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic mesh_item_t make_item(logic req, logic clr, logic [7:0] code,
                                           logic [7:0] a0, logic [7:0] b0,
                                           logic [7:0] a1, logic [7:0] b1,
                                           logic [7:0] a2, logic [7:0] b2);
    mesh_item_t it;
    it.req_type       = req;
    it.first_of_model = clr;
    it.code           = code;
    it.d0_first       = a0;
    it.d0_second      = b0;
    it.d1_first       = a1;
    it.d1_second      = b1;
    it.d2_first       = a2;
    it.d2_second      = b2;
    return it;
  endfunction

  function automatic mesh_item_t rand_item(logic req, logic clr, logic [7:0] code);
    return make_item(req, clr, code, rnd_byte(), rnd_byte(), rnd_byte(),
                     rnd_byte(), rnd_byte(), rnd_byte());
  endfunction

  // mostly well-formed, now and then a fully random item
  function automatic mesh_item_t with_noise(mesh_item_t it);
    if ($urandom_range(0, 19) != 0) return it;
    return rand_item(1'($urandom), $urandom_range(0, 7) == 0, rnd_byte());
  endfunction

  function automatic int pick_idle(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)", $time,
               name, $signed(exp_val), exp_val, $signed(act_val), act_val);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        decoded_q.push_back(decode_item(cur_item));
        items_sent <= items_sent + 1;
      end
      if (item_if.valid && !item_if.ready) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        item_if.valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        cur_item = stim_q.pop_front();
        item_if.req_type       <= cur_item.req_type;
        item_if.first_of_model <= cur_item.first_of_model;
        item_if.code           <= cur_item.code;
        item_if.d0_first       <= cur_item.d0_first;
        item_if.d0_second      <= cur_item.d0_second;
        item_if.d1_first       <= cur_item.d1_first;
        item_if.d1_second      <= cur_item.d1_second;
        item_if.d2_first       <= cur_item.d2_first;
        item_if.d2_second      <= cur_item.d2_second;
        item_if.valid          <= 1'b1;
        send_gap = pick_idle(send_calm);
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (!hold_done && results_taken >= HoldAfter) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      result_if.ready <= 1'b0;
    end else if (result_if.valid && result_if.ready) begin
      sink_wait = pick_idle(sink_calm);
      result_if.ready <= (sink_wait == 0);
    end else if (sink_wait > 0) begin
      sink_wait--;
      result_if.ready <= (sink_wait == 0);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      results_taken <= results_taken + 1;
      got.kind   = result_if.kind;
      got.status = result_if.status;
      got.first  = result_if.out_first;
      got.second = result_if.out_second;
      got.third  = result_if.out_third;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0b status %0b %0d %0d %0d",
                 $time, got.kind, got.status, $signed(got.first), $signed(got.second),
                 $signed(got.third));
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("out_first", want.first, got.first);
        check_field("out_second", want.second, got.second);
        check_field("out_third", want.third, got.third);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n_vert;
    int n_face;
    item_if.valid          = 1'b0;
    item_if.req_type       = 1'b0;
    item_if.first_of_model = 1'b0;
    item_if.code           = '0;
    item_if.d0_first       = '0;
    item_if.d0_second      = '0;
    item_if.d1_first       = '0;
    item_if.d1_second      = '0;
    item_if.d2_first       = '0;
    item_if.d2_second      = '0;
    result_if.ready        = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    idx_a = '0; idx_b = '0; idx_c = '0; last_idx = '0;

    // delta extremes, axis flags, strip codes, bad codes and clears
    stim_q.push_back(make_item(KIND_VERTEX, 1'b1, 8'h07, 8'h00, rnd_byte(), 8'h7F, rnd_byte(),
                               8'h80, 8'h00));
    stim_q.push_back(make_item(KIND_VERTEX, 1'b0, 8'h07, 8'hFF, 8'hFF, 8'hC0, 8'h00,
                               8'h40, rnd_byte()));
    stim_q.push_back(make_item(KIND_VERTEX, 1'b0, 8'hF8, 8'h10, rnd_byte(), 8'h90, 8'h12,
                               8'h7F, rnd_byte()));
    stim_q.push_back(rand_item(KIND_VERTEX, 1'b0, 8'h01));
    stim_q.push_back(rand_item(KIND_VERTEX, 1'b0, 8'h02));
    stim_q.push_back(rand_item(KIND_VERTEX, 1'b0, 8'h04));
    stim_q.push_back(make_item(KIND_VERTEX, 1'b0, 8'hFF, 8'h80, 8'h00, 8'h80, 8'h00,
                               8'h80, 8'h00));
    stim_q.push_back(make_item(KIND_FACE, 1'b1, CODE_FULL, 8'h80, 8'h00, 8'hFF, 8'hFF,
                               8'h00, rnd_byte()));
    stim_q.push_back(make_item(KIND_FACE, 1'b0, CODE_SHARE_B, 8'h41, rnd_byte(), rnd_byte(),
                               rnd_byte(), rnd_byte(), rnd_byte()));
    stim_q.push_back(make_item(KIND_FACE, 1'b0, CODE_SHARE_A, 8'hC1, 8'h23, rnd_byte(),
                               rnd_byte(), rnd_byte(), rnd_byte()));
    stim_q.push_back(make_item(KIND_FACE, 1'b0, CODE_SWAP, 8'h3F, rnd_byte(), rnd_byte(),
                               rnd_byte(), rnd_byte(), rnd_byte()));
    stim_q.push_back(rand_item(KIND_FACE, 1'b0, 8'h00));
    stim_q.push_back(rand_item(KIND_FACE, 1'b0, 8'h05));
    stim_q.push_back(rand_item(KIND_FACE, 1'b0, 8'hFF));
    stim_q.push_back(rand_item(KIND_FACE, 1'b0, 8'h84));
    stim_q.push_back(rand_item(KIND_FACE, 1'b1, 8'h00));
    stim_q.push_back(make_item(KIND_FACE, 1'b0, CODE_SHARE_B, 8'h40, rnd_byte(), rnd_byte(),
                               rnd_byte(), rnd_byte(), rnd_byte()));
    stim_q.push_back(rand_item(KIND_VERTEX, 1'b1, 8'h00));
    stim_q.push_back(rand_item(KIND_FACE, 1'b0, CODE_SWAP));
    stim_q.push_back(make_item(KIND_FACE, 1'b0, CODE_FULL, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                               8'hFF, 8'hFF));
    stim_q.push_back(make_item(KIND_FACE, 1'b0, CODE_FULL, 8'h00, rnd_byte(), 8'h00,
                               rnd_byte(), 8'h00, rnd_byte()));

    // random models: a clearing vertex, vertices, then a strip of faces
    total_items = stim_q.size() + RandomItems;
    while (stim_q.size() < total_items) begin
      stim_q.push_back(rand_item(KIND_VERTEX, 1'b1, rnd_byte()));
      n_vert = $urandom_range(1, 30);
      repeat (n_vert) stim_q.push_back(with_noise(rand_item(KIND_VERTEX, 1'b0, rnd_byte())));
      stim_q.push_back(rand_item(KIND_FACE, 1'b0, CODE_FULL));
      n_face = $urandom_range(1, 40);
      repeat (n_face) begin
        if ($urandom_range(0, 9) != 0) begin
          stim_q.push_back(with_noise(rand_item(KIND_FACE, 1'b0,
                                                strip_codes[$urandom_range(0, 3)])));
        end else begin
          stim_q.push_back(rand_item(KIND_FACE, 1'b0, rnd_byte()));
        end
      end
    end
    total_items = stim_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (items_sent != total_items || results_taken != total_items) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
